[sv/glstk_pkg.sv]
// shared types, constants and helpers for the growable lifo stack
package glstk_pkg;

    localparam int DEPTH    = 1024;
    localparam int WORD_W   = 32;
    localparam int CAP_W    = 16;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    localparam logic [CAP_W-1:0]  CAP_MAX        = {CAP_W{1'b1}};
    localparam logic [CAP_W-1:0]  INIT_CAP_RESET = CAP_W'(10);
    localparam logic [WORD_W-1:0] POP_ERR_WORD   = {WORD_W{1'b1}};
    localparam logic [CNT_W-1:0]  COUNT_FULL     = CNT_W'(DEPTH);

    // register index taken from paddr[APB_AW-1:2]
    localparam logic REG_INIT_CAP = 1'b0;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_RESIZE = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_POP_WAIT
    } t_state;

    typedef struct packed {
        logic exec;      // apply the accepted word to count and capacity
        logic load_pop;  // capture ram read data as the popped word
    } t_dp_cmd;

    typedef struct packed {
        logic reads_mem; // the offered word is a pop of a non-empty stack
    } t_dp_stat;

    // doubling with 0 -> 1 and saturation at the top
    function automatic logic [CAP_W-1:0] grown_capacity(input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] res;
        if (cap == '0) begin
            res = CAP_W'(1);
        end else if (cap > (CAP_MAX >> 1)) begin
            res = CAP_MAX;
        end else begin
            res = {cap[CAP_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

[sv/glstk_channels.sv]
// valid/ready channel interfaces for operation and result words
interface glstk_in_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      operation;
    logic signed [glstk_pkg::WORD_W-1:0] push_value;
    logic [glstk_pkg::CAP_W-1:0]     new_capacity;

    modport source (output valid, output operation, output push_value,
                    output new_capacity, input ready);
    modport sink   (input valid, input operation, input push_value,
                    input new_capacity, output ready);
endinterface

interface glstk_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [glstk_pkg::WORD_W-1:0] pop_value;
    logic [1:0]                      status;
    logic [glstk_pkg::CAP_W-1:0]     capacity;
    logic [glstk_pkg::CNT_W-1:0]     entries_held;

    modport source (output valid, output pop_value, output status,
                    output capacity, output entries_held, input ready);
    modport sink   (input valid, input pop_value, input status,
                    input capacity, input entries_held, output ready);
endinterface

[sv/glstk_ram.sv]
// generic single write port, single read port ram with registered read
module glstk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[sv/glstk_ctrl.sv]
// handshake and sequencing state machine
module glstk_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  glstk_pkg::t_dp_stat i_stat,
    output glstk_pkg::t_dp_cmd  o_cmd
);
    import glstk_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_out_valid    = r_out_valid && !i_out_ready;
        o_in_ready     = 1'b0;
        o_cmd.exec     = 1'b0;
        o_cmd.load_pop = 1'b0;
        case (r_state)
            S_IDLE: begin
                // output slot free or emptying this cycle
                o_in_ready = !r_out_valid || i_out_ready;
                o_cmd.exec = i_in_valid && o_in_ready;
                if (o_cmd.exec) begin
                    if (i_stat.reads_mem) begin
                        n_state = S_POP_WAIT;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            S_POP_WAIT: begin
                o_cmd.load_pop = 1'b1;
                n_out_valid    = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
endmodule

[sv/glstk_dp.sv]
// count, capacity, config register, stack ram and result registers
module glstk_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  glstk_pkg::t_dp_cmd                    i_cmd,
    output glstk_pkg::t_dp_stat                   o_stat,
    input  logic [1:0]                            i_operation,
    input  logic signed [glstk_pkg::WORD_W-1:0]   i_push_value,
    input  logic [glstk_pkg::CAP_W-1:0]           i_new_capacity,
    input  logic                                  i_cfg_we,
    input  logic [glstk_pkg::CAP_W-1:0]           i_cfg_data,
    output logic [glstk_pkg::CAP_W-1:0]           o_init_cap,
    output logic signed [glstk_pkg::WORD_W-1:0]   o_pop_value,
    output logic [1:0]                            o_status,
    output logic [glstk_pkg::CAP_W-1:0]           o_capacity,
    output logic [glstk_pkg::CNT_W-1:0]           o_entries_held
);
    import glstk_pkg::*;

    logic [CNT_W-1:0]  r_count, n_count;
    logic [CAP_W-1:0]  r_cap, n_cap;
    logic [CAP_W-1:0]  r_init_cap, n_init_cap;
    logic [WORD_W-1:0] r_pop_value, n_pop_value;
    t_status           r_status, n_status;
    logic [CAP_W-1:0]  r_out_cap, n_out_cap;
    logic [CNT_W-1:0]  r_out_cnt, n_out_cnt;

    logic [CNT_W-1:0]  w_count_dec;
    logic              w_empty;
    logic              w_full;
    logic              w_ram_we;
    logic [WORD_W-1:0] w_ram_rdata;
    t_op               w_op;

    assign w_op        = t_op'(i_operation);
    assign w_count_dec = r_count - CNT_W'(1);
    assign w_empty     = (r_count == '0);
    assign w_full      = (r_count >= COUNT_FULL);
    assign w_ram_we    = i_cmd.exec && (w_op == OP_PUSH) && !w_full;

    assign o_stat.reads_mem = (w_op == OP_POP) && !w_empty;

    glstk_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_push_value),
        .i_raddr (w_count_dec[ADDR_W-1:0]),
        .o_rdata (w_ram_rdata)
    );

    always_comb begin
        n_count     = r_count;
        n_cap       = r_cap;
        n_init_cap  = r_init_cap;
        n_pop_value = r_pop_value;
        n_status    = r_status;
        n_out_cap   = r_out_cap;
        n_out_cnt   = r_out_cnt;

        if (i_cfg_we) begin
            n_init_cap = i_cfg_data;
            n_cap      = i_cfg_data;
        end else if (i_cmd.exec) begin
            n_pop_value = '0;
            n_status    = ST_OK;
            case (w_op)
                OP_PUSH: begin
                    if (w_full) begin
                        n_status = ST_OVERFLOW;
                    end else begin
                        if (CMP_W'(r_count) >= CMP_W'(r_cap)) begin
                            n_cap = grown_capacity(r_cap);
                        end
                        n_count = r_count + CNT_W'(1);
                    end
                end
                OP_POP: begin
                    if (w_empty) begin
                        n_pop_value = POP_ERR_WORD;
                        n_status    = ST_UNDERFLOW;
                    end else begin
                        n_count = w_count_dec;
                    end
                end
                OP_RESIZE: begin
                    n_cap = i_new_capacity;
                    if (CMP_W'(r_count) > CMP_W'(i_new_capacity)) begin
                        n_count = CNT_W'(i_new_capacity);
                    end
                end
                default: begin
                end
            endcase
            n_out_cap = n_cap;
            n_out_cnt = n_count;
        end

        if (i_cmd.load_pop) begin
            n_pop_value = w_ram_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_cap      <= INIT_CAP_RESET;
            r_init_cap <= INIT_CAP_RESET;
        end else begin
            r_count    <= n_count;
            r_cap      <= n_cap;
            r_init_cap <= n_init_cap;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pop_value <= n_pop_value;
        r_status    <= n_status;
        r_out_cap   <= n_out_cap;
        r_out_cnt   <= n_out_cnt;
    end

    assign o_init_cap     = r_init_cap;
    assign o_pop_value    = r_pop_value;
    assign o_status       = r_status;
    assign o_capacity     = r_out_cap;
    assign o_entries_held = r_out_cnt;
endmodule

[sv/growable_lifo_stack.sv]
// push, resize, no-op and empty-stack pop results are valid in the cycle after accept
// a pop of a non-empty stack is valid after the registered ram read and the pop_wait capture
// throughput: one push or resize word per cycle while results are taken; none in pop_wait
// in idle, a new word is taken while the previous result is being taken on the same edge
// reset (synchronous, active low): count 0, capacity and initial_capacity 10, output empty
// stack ram contents are not cleared; entries are only read below the count
module growable_lifo_stack (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    glstk_in_if.sink                      i_cmd,
    glstk_out_if.source                   o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [glstk_pkg::APB_AW-1:0]  paddr,
    input  logic [glstk_pkg::APB_DW-1:0]  pwdata,
    output logic [glstk_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);
    import glstk_pkg::*;

    t_dp_cmd          w_cmd;
    t_dp_stat         w_stat;
    logic             w_cfg_we;
    logic [CAP_W-1:0] w_init_cap;

    // apb: no wait states, write lands on the access phase
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_INIT_CAP);
    // only one register, so every read returns initial_capacity
    assign prdata   = APB_DW'(w_init_cap);

    // controller: owns the handshake, sequences the pop read
    glstk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // datapath: count and capacity update, stack ram, result word registers
    glstk_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_operation    (i_cmd.operation),
        .i_push_value   (i_cmd.push_value),
        .i_new_capacity (i_cmd.new_capacity),
        .i_cfg_we       (w_cfg_we),
        .i_cfg_data     (pwdata[CAP_W-1:0]),
        .o_init_cap     (w_init_cap),
        .o_pop_value    (o_res.pop_value),
        .o_status       (o_res.status),
        .o_capacity     (o_res.capacity),
        .o_entries_held (o_res.entries_held)
    );
endmodule

[sv/glstk_chk.sv]
// port-level checker for the growable lifo stack, with its bind
module glstk_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic signed [glstk_pkg::WORD_W-1:0] i_pop_value,
    input logic [1:0]                          i_status,
    input logic [glstk_pkg::CNT_W-1:0]         i_entries_held
);
    import glstk_pkg::*;

    // stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_pop_value) && $stable(i_entries_held))
        else $error("result word changed while stalled");

    // underflow only on an empty stack, with the error word
    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_UNDERFLOW) |->
            (i_entries_held == '0) && (i_pop_value == -1))
        else $error("underflow with non-empty stack or bad word");

    // overflow only when full
    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_OVERFLOW) |-> (i_entries_held == COUNT_FULL))
        else $error("overflow reported below full depth");

    // count never exceeds the depth
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_entries_held <= COUNT_FULL))
        else $error("entries held above depth");
endmodule

bind growable_lifo_stack glstk_chk u_glstk_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_pop_value    (o_res.pop_value),
    .i_status       (o_res.status),
    .i_entries_held (o_res.entries_held)
);
